// ===== hdl/ntc_adc_to_celsius_defines.svh =====
// assertion macros shared by the ntc converter rtl
`ifndef NTC_ADC_TO_CELSIUS_DEFINES_SVH
`define NTC_ADC_TO_CELSIUS_DEFINES_SVH

// property checked on every rising clock edge, off while in reset
`define NTC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("ntc converter assertion failed");

// consequent in the cycle after the antecedent
`define NTC_ASSERT_NEXT(lbl, ante, cons) \
	`NTC_ASSERT(lbl, (ante) |=> (cons))

`endif

// ===== hdl/ntc_pkg.sv =====
// types, constants and tables of the ntc to celsius converter
`timescale 1ns / 1ps

package ntc_pkg;

	localparam int ADC_BITS_DEF = 12;

	localparam int MV_W    = 13;
	localparam int OHM_W   = 16;
	localparam int BETA_W  = 13;
	localparam int TK_W    = 16;
	localparam int CFG_W   = 16;
	localparam int RNUM_W  = OHM_W + MV_W;
	localparam int RAT_N_W = RNUM_W + 7;
	localparam int RATIO_W = 16;
	localparam int RECIP_W = 27;
	localparam int LNM_W   = 13;
	localparam int LNK_W   = 23;
	localparam int TC_W    = 14;

	localparam logic [MV_W-1:0]   REF_MV_RST  = 13'd5000;
	localparam logic [MV_W-1:0]   SUP_MV_RST  = 13'd5000;
	localparam logic [OHM_W-1:0]  PULL_RST    = 16'd10000;
	localparam logic [OHM_W-1:0]  NOM_RST     = 16'd10000;
	localparam logic [BETA_W-1:0] BETA_RST    = 13'd3950;
	localparam logic [TK_W-1:0]   T0_RST      = 16'd29815;

	localparam logic [13:0]        LN_TEN      = 14'd2302;
	localparam logic [14:0]        LN_HUNDRED  = 15'd4605;
	localparam logic [RECIP_W-1:0] RECIP_SCALE = 27'd100000000;
	localparam logic [RECIP_W-1:0] ZERO_C_CK   = 27'd27315;
	localparam logic [RECIP_W-1:0] TOP_C_CK    = 27'd39815;
	localparam logic [TC_W-1:0]    MAX_CENTI_C = 14'd12500;
	localparam logic [RAT_N_W-1:0] RATIO_CAP   = 36'd60000;

	typedef enum logic [2:0] {
		CFG_REF_MV  = 3'd0,
		CFG_SUP_MV  = 3'd1,
		CFG_PULL    = 3'd2,
		CFG_NOM     = 3'd3,
		CFG_BETA    = 3'd4,
		CFG_T0      = 3'd5
	} cfg_idx_t;

	// fields that ride alongside the datapath between the later stages
	typedef struct packed {
		logic               fault;
		logic               sign;
		logic [RECIP_W-1:0] recip;
	} carry_t;

	// ln(n) * 1000, truncated
	localparam logic [12:0] LN_TAB [100] = '{
		13'd0,    13'd0,    13'd693,  13'd1098, 13'd1386, 13'd1609, 13'd1791, 13'd1945,
		13'd2079, 13'd2197, 13'd2302, 13'd2397, 13'd2484, 13'd2564, 13'd2639, 13'd2708,
		13'd2772, 13'd2833, 13'd2890, 13'd2944, 13'd2995, 13'd3044, 13'd3091, 13'd3135,
		13'd3178, 13'd3218, 13'd3258, 13'd3295, 13'd3332, 13'd3367, 13'd3401, 13'd3433,
		13'd3465, 13'd3496, 13'd3526, 13'd3555, 13'd3583, 13'd3610, 13'd3637, 13'd3663,
		13'd3688, 13'd3713, 13'd3737, 13'd3761, 13'd3784, 13'd3806, 13'd3828, 13'd3850,
		13'd3871, 13'd3891, 13'd3912, 13'd3931, 13'd3951, 13'd3970, 13'd3988, 13'd4007,
		13'd4025, 13'd4043, 13'd4060, 13'd4077, 13'd4094, 13'd4110, 13'd4127, 13'd4143,
		13'd4158, 13'd4174, 13'd4189, 13'd4204, 13'd4219, 13'd4234, 13'd4248, 13'd4262,
		13'd4276, 13'd4290, 13'd4304, 13'd4317, 13'd4330, 13'd4343, 13'd4356, 13'd4369,
		13'd4382, 13'd4394, 13'd4406, 13'd4418, 13'd4430, 13'd4442, 13'd4454, 13'd4465,
		13'd4477, 13'd4488, 13'd4499, 13'd4510, 13'd4521, 13'd4532, 13'd4543, 13'd4553,
		13'd4564, 13'd4574, 13'd4584, 13'd4595
	};

	// x / 10 by reciprocal, exact for every 16-bit x
	function automatic logic [RATIO_W-1:0] div10(input logic [RATIO_W-1:0] x);
		logic [31:0] p;
		p = x * 16'd52429;
		return RATIO_W'(p >> 19);
	endfunction

endpackage

// ===== hdl/ntc_div.sv =====
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps

module ntc_div #(
	parameter int NUM_W  = 29,
	parameter int DEN_W  = 13,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	output logic [NUM_W-1:0]  quo,
	output logic [SIDE_W-1:0] side_out
);

	// acc shifts the dividend out at the top and the quotient in at the bottom
	logic              v_s    [1:NUM_W];
	logic [NUM_W-1:0]  acc_s  [1:NUM_W];
	logic [DEN_W-1:0]  rem_s  [1:NUM_W];
	logic [DEN_W-1:0]  den_s  [1:NUM_W];
	logic [SIDE_W-1:0] side_s [1:NUM_W];

	for (genvar i = 0; i < NUM_W; i++) begin : g_stage
		logic              v_i;
		logic [NUM_W-1:0]  acc_i;
		logic [DEN_W-1:0]  rem_i;
		logic [DEN_W-1:0]  den_i;
		logic [SIDE_W-1:0] side_i;
		logic [DEN_W:0]    trial;
		logic              fits;
		logic [DEN_W-1:0]  rem_n;

		if (i == 0) begin : g_first
			assign v_i    = in_valid;
			assign acc_i  = num;
			assign rem_i  = '0;
			assign den_i  = den;
			assign side_i = side_in;
		end else begin : g_rest
			assign v_i    = v_s[i];
			assign acc_i  = acc_s[i];
			assign rem_i  = rem_s[i];
			assign den_i  = den_s[i];
			assign side_i = side_s[i];
		end

		always_comb begin
			trial = {rem_i, acc_i[NUM_W-1]};
			fits  = trial >= {1'b0, den_i};
			rem_n = fits ? DEN_W'(trial - {1'b0, den_i}) : trial[DEN_W-1:0];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				acc_s[i+1]  <= {acc_i[NUM_W-2:0], fits};
				rem_s[i+1]  <= rem_n;
				den_s[i+1]  <= den_i;
				side_s[i+1] <= side_i;
			end
		end
	end

	assign out_valid = v_s[NUM_W];
	assign quo       = acc_s[NUM_W];
	assign side_out  = side_s[NUM_W];

endmodule

// ===== hdl/ntc_adc_to_celsius.sv =====
// top level of the ntc adc code to whole degrees celsius converter
`timescale 1ns / 1ps
`include "ntc_adc_to_celsius_defines.svh"

// usage
// - input channel: adc_code with in_valid / in_ready, one code per transfer
// - output channel: temp_celsius with out_valid / out_ready, one result per code,
//   0..125 degrees, 0 on any fault (zero code or voltage, voltage at or above supply,
//   zero resistance, zero nominal, beta or reference temperature, reciprocal not positive)
// - config channel: cfg_index / cfg_data with cfg_valid / cfg_ready, always ready;
//   indexes above the register list are ignored; write only while idle
// - throughput: one code per cycle while the receiver takes results, fully pipelined
// - pipeline: almost all stages lie in four one-bit-per-stage dividers
//   (resistance 29, ratio 36, log over beta 23, reciprocal temperature 27)
//   plus 14 surrounding stages; 1e8 / t0 runs beside the resistance divider
// - reset: pipeline empties, registers go to 5000 mV, 5000 mV, 10 kohm,
//   10 kohm, 3950 K, 29815 cK
// - receiver stall: the whole pipeline freezes in place and in_ready drops
//   in the same cycle, nothing is lost or repeated
module ntc_adc_to_celsius #(
	parameter int ADC_BITS = ntc_pkg::ADC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [ADC_BITS-1:0] adc_code,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [6:0]          temp_celsius,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [ntc_pkg::CFG_W-1:0] cfg_data
);

	localparam int PROD_W = ADC_BITS + ntc_pkg::MV_W;

	// configuration registers
	logic [ntc_pkg::MV_W-1:0]   ref_mv_q;
	logic [ntc_pkg::MV_W-1:0]   sup_mv_q;
	logic [ntc_pkg::OHM_W-1:0]  pull_q;
	logic [ntc_pkg::OHM_W-1:0]  nom_q;
	logic [ntc_pkg::BETA_W-1:0] beta_q;
	logic [ntc_pkg::TK_W-1:0]   t0_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_mv_q <= ntc_pkg::REF_MV_RST;
			sup_mv_q <= ntc_pkg::SUP_MV_RST;
			pull_q   <= ntc_pkg::PULL_RST;
			nom_q    <= ntc_pkg::NOM_RST;
			beta_q   <= ntc_pkg::BETA_RST;
			t0_q     <= ntc_pkg::T0_RST;
		end else if (cfg_valid) begin
			case (ntc_pkg::cfg_idx_t'(cfg_index))
				ntc_pkg::CFG_REF_MV: ref_mv_q <= cfg_data[ntc_pkg::MV_W-1:0];
				ntc_pkg::CFG_SUP_MV: sup_mv_q <= cfg_data[ntc_pkg::MV_W-1:0];
				ntc_pkg::CFG_PULL:   pull_q   <= cfg_data;
				ntc_pkg::CFG_NOM:    nom_q    <= cfg_data;
				ntc_pkg::CFG_BETA:   beta_q   <= cfg_data[ntc_pkg::BETA_W-1:0];
				ntc_pkg::CFG_T0:     t0_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// one enable for every stage: advance unless the result is stuck
	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// s1: code times reference, static faults
	logic              v_s1, fault_s1;
	logic [PROD_W-1:0] prod_s1;
	logic              code_zero_s1;

	// s2: millivolts and headroom to supply
	logic                     v_s2, fault_s2;
	logic [ntc_pkg::MV_W-1:0] mv_s2, diff_s2;

	// s3: resistance numerator
	logic                       v_s3, fault_s3;
	logic [ntc_pkg::RNUM_W-1:0] rnum_s3;
	logic [ntc_pkg::MV_W-1:0]   diff_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1      <= adc_code * ref_mv_q;
			code_zero_s1 <= adc_code == '0;
			fault_s1     <= (adc_code == '0) || (nom_q == '0) || (beta_q == '0);
			mv_s2        <= ntc_pkg::MV_W'(prod_s1 >> ADC_BITS);
			diff_s2      <= sup_mv_q - ntc_pkg::MV_W'(prod_s1 >> ADC_BITS);
			fault_s2     <= fault_s1 || (ntc_pkg::MV_W'(prod_s1 >> ADC_BITS) == '0) ||
				(ntc_pkg::MV_W'(prod_s1 >> ADC_BITS) >= sup_mv_q);
			rnum_s3      <= pull_q * mv_s2;
			diff_s3      <= diff_s2;
			fault_s3     <= fault_s2;
		end
	end

	// resistance divider and 1e8 / t0 in lockstep
	logic                       v_r, fault_r, t0_zero_r, v_t0;
	logic [ntc_pkg::RNUM_W-1:0] r_q, recip_full;

	ntc_div #(.NUM_W(ntc_pkg::RNUM_W), .DEN_W(ntc_pkg::MV_W), .SIDE_W(1)) u_div_r (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s3), .num(rnum_s3), .den(diff_s3), .side_in(fault_s3),
		.out_valid(v_r), .quo(r_q), .side_out(fault_r)
	);

	ntc_div #(.NUM_W(ntc_pkg::RNUM_W), .DEN_W(ntc_pkg::TK_W), .SIDE_W(1)) u_div_t0 (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s3), .num(ntc_pkg::RNUM_W'(ntc_pkg::RECIP_SCALE)), .den(t0_q),
		.side_in(t0_q == '0),
		.out_valid(v_t0), .quo(recip_full), .side_out(t0_zero_r)
	);

	// s4: pick larger over smaller, s5: times 100
	logic                        v_s4, v_s5, ge_s4;
	logic [ntc_pkg::RNUM_W-1:0]  a_s4, b_s4, b_s5;
	ntc_pkg::carry_t             c_s4, c_s5;
	logic [ntc_pkg::RAT_N_W-1:0] num_s5;
	logic                        ge_r;

	assign ge_r = r_q >= ntc_pkg::RNUM_W'(nom_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_r && v_t0;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ge_s4       <= ge_r;
			a_s4        <= ge_r ? r_q : ntc_pkg::RNUM_W'(nom_q);
			b_s4        <= ge_r ? ntc_pkg::RNUM_W'(nom_q) : r_q;
			c_s4.fault  <= fault_r || t0_zero_r || (r_q == '0);
			c_s4.sign   <= ge_r;
			c_s4.recip  <= recip_full[ntc_pkg::RECIP_W-1:0];
			num_s5      <= a_s4 * 7'd100;
			b_s5        <= b_s4;
			c_s5        <= c_s4;
		end
	end

	// ratio divider
	logic                        v_rt;
	logic [ntc_pkg::RAT_N_W-1:0] ratio_q;
	ntc_pkg::carry_t             c_rt;

	ntc_div #(.NUM_W(ntc_pkg::RAT_N_W), .DEN_W(ntc_pkg::RNUM_W),
		.SIDE_W($bits(ntc_pkg::carry_t))) u_div_ratio (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s5), .num(num_s5), .den(b_s5), .side_in(c_s5),
		.out_valid(v_rt), .quo(ratio_q), .side_out(c_rt)
	);

	// s6: cap, s7..s9: at most one decade off per stage, s10: table lookup, s11: times 1000
	logic                        v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;
	logic [ntc_pkg::RATIO_W-1:0] ratio_s6, x_s7, x_s8, x_s9;
	logic [1:0]                  dec_s7, dec_s8, dec_s9;
	ntc_pkg::carry_t             c_s6, c_s7, c_s8, c_s9, c_s10, c_s11;
	logic [ntc_pkg::LNM_W-1:0]   mag_s10;
	logic [ntc_pkg::LNK_W-1:0]   lnk_s11;
	logic [13:0]                 lnv;
	logic [14:0]                 ln_signed;

	always_comb begin
		lnv       = 14'(ntc_pkg::LN_TAB[x_s9[6:0]]) + dec_s9 * ntc_pkg::LN_TEN;
		ln_signed = {1'b0, lnv} - ntc_pkg::LN_HUNDRED;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else if (en) begin
			v_s6  <= v_rt;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ratio_s6 <= (ratio_q > ntc_pkg::RATIO_CAP) ? ntc_pkg::RATIO_W'(ntc_pkg::RATIO_CAP)
				: ratio_q[ntc_pkg::RATIO_W-1:0];
			c_s6     <= c_rt;
			x_s7     <= (ratio_s6 >= 16'd100) ? ntc_pkg::div10(ratio_s6) : ratio_s6;
			dec_s7   <= (ratio_s6 >= 16'd100) ? 2'd1 : 2'd0;
			c_s7     <= c_s6;
			x_s8     <= (x_s7 >= 16'd100) ? ntc_pkg::div10(x_s7) : x_s7;
			dec_s8   <= dec_s7 + 2'((x_s7 >= 16'd100) ? 1 : 0);
			c_s8     <= c_s7;
			x_s9     <= (x_s8 >= 16'd100) ? ntc_pkg::div10(x_s8) : x_s8;
			dec_s9   <= dec_s8 + 2'((x_s8 >= 16'd100) ? 1 : 0);
			c_s9     <= c_s8;
			// sign of the log term: log sign flipped when r is below nominal
			mag_s10  <= ln_signed[14] ? ntc_pkg::LNM_W'(-ln_signed)
				: ln_signed[ntc_pkg::LNM_W-1:0];
			c_s10.fault <= c_s9.fault;
			c_s10.sign  <= ln_signed[14] ^ !c_s9.sign;
			c_s10.recip <= c_s9.recip;
			lnk_s11  <= mag_s10 * 10'd1000;
			c_s11    <= c_s10;
		end
	end

	// log over beta divider, magnitude only, truncates toward zero
	logic                      v_lb;
	logic [ntc_pkg::LNK_W-1:0] lb_q;
	ntc_pkg::carry_t           c_lb;

	ntc_div #(.NUM_W(ntc_pkg::LNK_W), .DEN_W(ntc_pkg::BETA_W),
		.SIDE_W($bits(ntc_pkg::carry_t))) u_div_beta (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s11), .num(lnk_s11), .den(beta_q), .side_in(c_s11),
		.out_valid(v_lb), .quo(lb_q), .side_out(c_lb)
	);

	// s12: reciprocal temperature
	logic                        v_s12, fault_s12;
	logic [ntc_pkg::RECIP_W-1:0] inv_s12;
	logic [28:0]                 inv_sum;

	always_comb begin
		inv_sum = c_lb.sign ? ({2'b0, c_lb.recip} - {6'b0, lb_q})
			: ({2'b0, c_lb.recip} + {6'b0, lb_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s12 <= 1'b0;
		end else if (en) begin
			v_s12 <= v_lb;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inv_s12   <= inv_sum[ntc_pkg::RECIP_W-1:0];
			fault_s12 <= c_lb.fault || inv_sum[28] || (inv_sum == '0);
		end
	end

	// kelvin divider
	logic                        v_tk, fault_tk;
	logic [ntc_pkg::RECIP_W-1:0] tk_q;

	ntc_div #(.NUM_W(ntc_pkg::RECIP_W), .DEN_W(ntc_pkg::RECIP_W), .SIDE_W(1)) u_div_tk (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s12), .num(ntc_pkg::RECIP_SCALE), .den(inv_s12), .side_in(fault_s12),
		.out_valid(v_tk), .quo(tk_q), .side_out(fault_tk)
	);

	// s13: centidegrees clamped, s14: whole degrees by reciprocal of 100
	logic                     v_s13, fault_s13, v_s14;
	logic [ntc_pkg::TC_W-1:0] tc_s13;
	logic [6:0]               temp_s14;
	logic [26:0]              deg_prod;

	assign deg_prod = tc_s13 * 13'd5243;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s13 <= 1'b0;
			v_s14 <= 1'b0;
		end else if (en) begin
			v_s13 <= v_tk;
			v_s14 <= v_s13;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (tk_q < ntc_pkg::ZERO_C_CK) begin
				tc_s13 <= '0;
			end else if (tk_q >= ntc_pkg::TOP_C_CK) begin
				tc_s13 <= ntc_pkg::MAX_CENTI_C;
			end else begin
				tc_s13 <= ntc_pkg::TC_W'(tk_q - ntc_pkg::ZERO_C_CK);
			end
			fault_s13 <= fault_tk;
			temp_s14  <= fault_s13 ? 7'd0 : deg_prod[25:19];
		end
	end

	assign out_valid    = v_s14;
	assign temp_celsius = temp_s14;

	// checks
	`NTC_ASSERT(a_out_range, out_valid |-> (temp_celsius <= 7'd125))
	`NTC_ASSERT_NEXT(a_zero_code, in_valid && in_ready && (adc_code == '0), fault_s1 && code_zero_s1)
	`NTC_ASSERT(a_ratio_cap, v_s6 |-> (ratio_s6 <= 16'd60000))
	`NTC_ASSERT(a_log_index, v_s9 |-> (x_s9 < 16'd100))
	`NTC_ASSERT(a_div_lockstep, v_r == v_t0)

endmodule

// ===== tb/ntc_adc_to_celsius_tb.sv =====
// testbench for the ntc adc code to celsius converter, with a scoreboard class
`timescale 1ns / 1ps

module ntc_adc_to_celsius_tb;

	localparam int IDLE_LIMIT = 5000;
	localparam int TAIL_CYCLES = 300;

	// expected temperatures and a private copy of the register file
	class temp_scoreboard;
		longint ref_mv, sup_mv, pull_ohm, nom_ohm, beta_k, t0_ck;
		logic [6:0] pending_temps[$];
		int errors;

		function new();
			ref_mv = 5000;
			sup_mv = 5000;
			pull_ohm = 10000;
			nom_ohm = 10000;
			beta_k = 3950;
			t0_ck = 29815;
			errors = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [15:0] data);
			case (idx)
				ntc_pkg::CFG_REF_MV: ref_mv = data[12:0];
				ntc_pkg::CFG_SUP_MV: sup_mv = data[12:0];
				ntc_pkg::CFG_PULL:   pull_ohm = data;
				ntc_pkg::CFG_NOM:    nom_ohm = data;
				ntc_pkg::CFG_BETA:   beta_k = data[12:0];
				ntc_pkg::CFG_T0:     t0_ck = data;
				default: ;
			endcase
		endfunction

		// ln(x) * 1000 by decades plus table
		function longint ln_milli(longint x);
			longint decades;
			decades = 0;
			while (x >= 100) begin
				x = x / 10;
				decades++;
			end
			return longint'(ntc_pkg::LN_TAB[x]) + decades * 2302;
		endfunction

		function logic [6:0] celsius_of(logic [11:0] code);
			longint mv, diff, r, ratio, log_term, recip, tk, tc;
			if (code == 0) return 0;
			if (nom_ohm == 0 || beta_k == 0 || t0_ck == 0) return 0;
			mv = longint'(code) * ref_mv / 4096;
			if (mv == 0 || mv >= sup_mv) return 0;
			diff = sup_mv - mv;
			r = pull_ohm * mv / diff;
			if (r == 0) return 0;
			if (r >= nom_ohm)
				ratio = r * 100 / nom_ohm;
			else
				ratio = nom_ohm * 100 / r;
			if (ratio > 60000) ratio = 60000;
			log_term = ln_milli(ratio) - 4605;
			if (r < nom_ohm) log_term = -log_term;
			recip = 100000000 / t0_ck + (log_term * 1000) / beta_k;
			if (recip <= 0) return 0;
			tk = 100000000 / recip;
			tc = tk - 27315;
			if (tc < 0) tc = 0;
			if (tc > 12500) tc = 12500;
			return 7'(tc / 100);
		endfunction

		function void note_code(logic [11:0] code);
			pending_temps.push_back(celsius_of(code));
		endfunction

		function void check_temp(logic [6:0] actual);
			logic [6:0] want;
			if (pending_temps.size() == 0) begin
				$error("temp_celsius: unexpected result %0d", actual);
				errors++;
				return;
			end
			want = pending_temps.pop_front();
			if (want !== actual) begin
				$error("temp_celsius: expected %0d, actual %0d", want, actual);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [11:0] adc_code;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [6:0]  temp_celsius;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	temp_scoreboard sb;
	int stall_pct;   // chance of a receiver stall in percent
	int idle_cycles = 0;

	ntc_adc_to_celsius dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.adc_code(adc_code),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.temp_celsius(temp_celsius),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
	end

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: random stalls, long freezes of the pipeline when the stall chance is above 50 percent
	always @(posedge clk) begin
		if ($urandom_range(199) == 0)
			out_ready <= 1'b0;
		else if (!out_ready && $urandom_range(3) != 0 && stall_pct > 50)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// monitor: sample every transfer on all three channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_temp(temp_celsius);
			if (in_valid && in_ready)
				sb.note_code(adc_code);
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
		end
	end

	// watchdog: cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// one code transfer, valid stays up if the caller sends straight on
	task automatic send_code(input logic [11:0] code);
		in_valid <= 1'b1;
		adc_code <= code;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic pause_sender(input int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// send a run of codes in bursts with random gaps
	task automatic send_burst_run(input int count);
		int left;
		left = 0;
		for (int n = 0; n < count; n++) begin
			if (left == 0) begin
				if ($urandom_range(2) != 0) pause_sender($urandom_range(1, 12));
				left = $urandom_range(1, 20);
			end
			left--;
			case ($urandom_range(9))
				0: send_code(12'($urandom_range(15)));
				1: send_code(12'(4095 - $urandom_range(15)));
				default: send_code(12'($urandom));
			endcase
		end
		in_valid <= 1'b0;
	endtask

	task automatic drain;
		@(posedge clk);
		while (sb.pending_temps.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(input ntc_pkg::cfg_idx_t idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_config(input logic [15:0] rmv, input logic [15:0] smv,
		input logic [15:0] pull, input logic [15:0] nom,
		input logic [15:0] beta, input logic [15:0] t0);
		write_reg(ntc_pkg::CFG_REF_MV, rmv);
		write_reg(ntc_pkg::CFG_SUP_MV, smv);
		write_reg(ntc_pkg::CFG_PULL, pull);
		write_reg(ntc_pkg::CFG_NOM, nom);
		write_reg(ntc_pkg::CFG_BETA, beta);
		write_reg(ntc_pkg::CFG_T0, t0);
	endtask

	// index beyond the register list, must leave everything alone
	task automatic write_unused_index;
		cfg_valid <= 1'b1;
		cfg_index <= 3'($urandom_range(6, 7));
		cfg_data <= 16'($urandom);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		sb = new();
		stall_pct = 20;
		arst_n = 1'b0;
		in_valid = 1'b0;
		adc_code = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed codes at reset settings: zero, ends of scale, single bits, alternating bits
		send_code(12'd0);
		send_code(12'd1);
		send_code(12'd4095);
		send_code(12'd4094);
		send_code(12'd2048);
		for (int b = 0; b < 12; b++) send_code(12'(1 << b));
		send_code(12'h555);
		send_code(12'haaa);
		pause_sender(3);

		// random at reset settings, then the sender holds off for a full drain
		send_burst_run(100);
		drain();

		for (int phase = 0; phase < 12; phase++) begin
			case (phase)
				0: load_config(16'd1000, 16'd1000, 16'd1, 16'd1, 16'd1000, 16'd20000);
				1: load_config(16'd5500, 16'd5500, 16'd65535, 16'd65535, 16'd6000, 16'd40000);
				// supply above reference: low codes give hot readings
				2: load_config(16'd1000, 16'd5500, 16'd10000, 16'd100, 16'd6000, 16'd29815);
				// zero pull-up and zero nominal
				3: load_config(16'd5000, 16'd3300, 16'd0, 16'd0, 16'd3950, 16'd29815);
				// zero beta and zero reference temperature
				4: load_config(16'd3300, 16'd3300, 16'd4700, 16'd4700, 16'd0, 16'd0);
				// upper bits above the 13-bit registers, ratio cap reached
				5: load_config(16'hffff, 16'hffff, 16'hffff, 16'd1, 16'hffff, 16'hffff);
				6: load_config(16'd3300, 16'd5000, 16'd1, 16'd65535, 16'd1000, 16'd40000);
				default: load_config(16'($urandom_range(1000, 5500)),
					16'($urandom_range(1000, 5500)),
					16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
					16'($urandom_range(1000, 6000)), 16'($urandom_range(20000, 40000)));
			endcase
			write_unused_index();
			stall_pct = (phase % 3 == 0) ? 0 : (phase % 3 == 1) ? 30 : 70;
			send_code(12'd0);
			send_code(12'd4095);
			send_burst_run(95);
			drain();
		end

		drain();
		repeat (TAIL_CYCLES) begin
			@(posedge clk);
			if (sb.pending_temps.size() != 0) break;
		end
		if (sb.pending_temps.size() != 0) begin
			$error("temp_celsius: %0d results never arrived", sb.pending_temps.size());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
